@@ hdl/srgb_to_cielab_unit_macros.svh @@
// Assertion macros shared by the sRGB to CIELAB modules.
`ifndef SRGB_TO_CIELAB_UNIT_MACROS_SVH
`define SRGB_TO_CIELAB_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property that must hold at every clock edge outside reset.
`define SRGBLAB_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("srgblab assertion failed");
// Condition that must never be seen outside reset.
`define SRGBLAB_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("srgblab forbidden condition");
`else
`define SRGBLAB_ASSERT(lbl, clk, rst_n, prop)
`define SRGBLAB_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

@@ hdl/srgblab_pkg.sv @@
// Types, constants and the linearization table of the sRGB to CIELAB converter.
package srgblab_pkg;
	localparam int FRAC_BITS_DEF = 8;
	localparam int Q_BITS = 24;
	localparam int CH_W = 8;
	localparam int LIN_W = 25;
	localparam int COEF_W = 14;
	localparam int XYZ_W = 38;
	localparam int WHITE_W = 18;
	localparam int NUM_W = 42;
	localparam int ROOT_W = 30;
	localparam int SQ_W = 36;
	localparam int SAT_W = 64;
	localparam int F_W = 30;
	localparam int VLIN_W = 18;
	localparam int LN_W = 31;
	localparam int RES_W = 42;
	localparam int FIFO_DEPTH = 4;

	localparam logic [NUM_W-1:0] KNEE_V = NUM_W'(148579);
	localparam logic [31:0] RECIP_1000 = 32'd2199023256;
	localparam int RECIP_SHIFT = 41;
	localparam logic [F_W-1:0] F_OFFSET = F_W'(((64'd16 << Q_BITS) + 64'd58) / 64'd116);
	localparam logic [LN_W-1:0] LIN_SLOPE = LN_W'(7787);
	localparam logic [LN_W-1:0] LIN_ROUND = LN_W'(500);

	localparam int L_MAX = 32767;
	localparam int AB_MAX = 32767;
	localparam int AB_MIN = -32768;

	localparam logic [WHITE_W-1:0] WHITE_X_RST = 18'd95047;
	localparam logic [WHITE_W-1:0] WHITE_Y_RST = 18'd100000;
	localparam logic [WHITE_W-1:0] WHITE_Z_RST = 18'd108883;

	typedef enum logic [1:0] {
		REG_WHITE_X = 2'd0,
		REG_WHITE_Y = 2'd1,
		REG_WHITE_Z = 2'd2
	} cfg_reg_t;

	typedef logic [COEF_W-1:0] matrix_t [3][3];
	localparam matrix_t MATRIX = '{
		'{14'd4124, 14'd3576, 14'd1805},
		'{14'd2126, 14'd7152, 14'd722},
		'{14'd193, 14'd1192, 14'd9505}
	};

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [14:0] lightness;
		logic signed [15:0] a_star;
		logic signed [15:0] b_star;
	} lab_t;

	typedef struct packed {
		logic [LIN_W-1:0] r;
		logic [LIN_W-1:0] g;
		logic [LIN_W-1:0] b;
	} lin_rgb_t;

	typedef struct packed {
		logic can_push;
		logic has_data;
	} fifo_stat_t;

	typedef logic [LIN_W-1:0] lin_tab_t [256];

	// Truncated Q24 fifth power that saturates once the product leaves 64 bits.
	function automatic logic [63:0] qpow5(input logic [63:0] r);
		logic [127:0] prod;
		logic [63:0] p;
		p = r;
		for (int i = 1; i < 5; i++) begin
			prod = 128'(p) * 128'(r);
			if (prod[127:64] != 64'd0) return '1;
			p = prod[87:24];
		end
		return p;
	endfunction

	function automatic logic [63:0] qroot5(input logic [63:0] x);
		logic [63:0] r;
		logic [63:0] c;
		r = '0;
		for (int b = 29; b >= 0; b--) begin
			c = r | (64'd1 << b);
			if (qpow5(c) <= x) r = c;
		end
		return r;
	endfunction

	function automatic logic [LIN_W-1:0] lin_value(input int c);
		logic [63:0] cc;
		logic [63:0] t;
		logic [63:0] u;
		cc = 64'(c);
		if (cc <= 64'd10)
			return LIN_W'((cc * 64'd100 * (64'd1 << Q_BITS) + 64'd164730) / 64'd329460);
		t = ((cc * 64'd1000 + 64'd14025) * (64'd1 << Q_BITS) + 64'd134512) / 64'd269025;
		u = (t * t) >> Q_BITS;
		return LIN_W'((u * qroot5(u)) >> Q_BITS);
	endfunction

	function automatic lin_tab_t build_lin();
		lin_tab_t tab;
		for (int i = 0; i < 256; i++) tab[i] = lin_value(i);
		return tab;
	endfunction

	localparam lin_tab_t LIN_TABLE = build_lin();
endpackage

@@ hdl/srgblab_front.sv @@
// Front end: takes pixel transfers and looks up the linear value of each channel.
module srgblab_front (
	input logic clk,
	input logic arst_n,
	input logic pixel_valid,
	output logic pixel_ready,
	input srgblab_pkg::pixel_t pixel,
	input srgblab_pkg::fifo_stat_t stat,
	output logic push,
	output srgblab_pkg::lin_rgb_t lin
);
	import srgblab_pkg::*;

	logic valid_s1;
	lin_rgb_t lin_s1;

	assign pixel_ready = !valid_s1 || stat.can_push;
	assign push = valid_s1 && stat.can_push;
	assign lin = lin_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pixel_ready) begin
			valid_s1 <= pixel_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pixel_ready && pixel_valid) begin
			lin_s1.r <= LIN_TABLE[pixel.red];
			lin_s1.g <= LIN_TABLE[pixel.green];
			lin_s1.b <= LIN_TABLE[pixel.blue];
		end
	end
endmodule

@@ hdl/srgblab_fifo.sv @@
// Short queue of linearized pixels between the front end and the arithmetic pipeline.
`include "srgb_to_cielab_unit_macros.svh"
module srgblab_fifo #(
	parameter int DEPTH = srgblab_pkg::FIFO_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input srgblab_pkg::lin_rgb_t wdata,
	input logic pop,
	output srgblab_pkg::lin_rgb_t rdata,
	output srgblab_pkg::fifo_stat_t stat
);
	import srgblab_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	lin_rgb_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] count_q;

	assign stat.can_push = count_q != CNT_W'(DEPTH);
	assign stat.has_data = count_q != '0;
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop) rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= wdata;
	end

	`SRGBLAB_NEVER(a_no_overflow, clk, arst_n, push && !stat.can_push)
	`SRGBLAB_NEVER(a_no_underflow, clk, arst_n, pop && !stat.has_data)
	`SRGBLAB_ASSERT(a_count_up, clk, arst_n, push && !pop |=> count_q == $past(count_q) + 1'b1)
endmodule

@@ hdl/srgblab_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
module srgblab_div (
	input logic clk,
	input logic en,
	input logic [srgblab_pkg::NUM_W-1:0] num,
	input logic [srgblab_pkg::WHITE_W-1:0] den,
	output logic [srgblab_pkg::NUM_W-1:0] quo
);
	import srgblab_pkg::*;

	logic [NUM_W-1:0] n_s [NUM_W];
	logic [NUM_W-1:0] q_s [NUM_W];
	logic [WHITE_W-1:0] rem_s [NUM_W];

	for (genvar k = 0; k < NUM_W; k++) begin : g_stage
		logic [NUM_W-1:0] n_src;
		logic [NUM_W-1:0] q_src;
		logic [WHITE_W-1:0] rem_src;
		logic [WHITE_W:0] trial;
		logic [WHITE_W:0] diff;
		logic ge;
		if (k == 0) begin : g_first
			assign n_src = num;
			assign q_src = '0;
			assign rem_src = '0;
		end else begin : g_next
			assign n_src = n_s[k-1];
			assign q_src = q_s[k-1];
			assign rem_src = rem_s[k-1];
		end
		assign trial = {rem_src, n_src[NUM_W-1]};
		assign ge = trial >= {1'b0, den};
		assign diff = trial - {1'b0, den};
		always_ff @(posedge clk) begin
			if (en) begin
				n_s[k] <= {n_src[NUM_W-2:0], 1'b0};
				q_s[k] <= {q_src[NUM_W-2:0], ge};
				rem_s[k] <= ge ? diff[WHITE_W-1:0] : trial[WHITE_W-1:0];
			end
		end
	end

	assign quo = q_s[NUM_W-1];
endmodule

@@ hdl/srgblab_cbrt.sv @@
// Pipelined Q24 cube root: two stages per result bit, square then cube and compare.
module srgblab_cbrt #(
	parameter int SIDE_W = 1
) (
	input logic clk,
	input logic en,
	input logic [srgblab_pkg::NUM_W-1:0] x,
	input logic [SIDE_W-1:0] side_in,
	output logic [srgblab_pkg::ROOT_W-1:0] root,
	output logic [SIDE_W-1:0] side_out
);
	import srgblab_pkg::*;

	localparam int SQF_W = 2 * ROOT_W;
	localparam int CUBE_W = SQ_W + ROOT_W;

	logic [ROOT_W-1:0] r_a_s [ROOT_W];
	logic [ROOT_W-1:0] c_a_s [ROOT_W];
	logic [SQ_W-1:0] sq_a_s [ROOT_W];
	logic [NUM_W-1:0] x_a_s [ROOT_W];
	logic [SIDE_W-1:0] side_a_s [ROOT_W];
	logic [ROOT_W-1:0] r_b_s [ROOT_W];
	logic [NUM_W-1:0] x_b_s [ROOT_W];
	logic [SIDE_W-1:0] side_b_s [ROOT_W];

	for (genvar k = 0; k < ROOT_W; k++) begin : g_bit
		logic [ROOT_W-1:0] r_src;
		logic [NUM_W-1:0] x_src;
		logic [SIDE_W-1:0] side_src;
		logic [ROOT_W-1:0] cand;
		logic [SQF_W-1:0] sq_full;
		logic [CUBE_W-1:0] cube_full;
		logic fits;
		if (k == 0) begin : g_first
			assign r_src = '0;
			assign x_src = x;
			assign side_src = side_in;
		end else begin : g_next
			assign r_src = r_b_s[k-1];
			assign x_src = x_b_s[k-1];
			assign side_src = side_b_s[k-1];
		end
		assign cand = r_src | (ROOT_W'(1) << (ROOT_W - 1 - k));
		assign sq_full = SQF_W'(cand) * SQF_W'(cand);
		always_ff @(posedge clk) begin
			if (en) begin
				r_a_s[k] <= r_src;
				c_a_s[k] <= cand;
				sq_a_s[k] <= sq_full[SQF_W-1:Q_BITS];
				x_a_s[k] <= x_src;
				side_a_s[k] <= side_src;
			end
		end
		// A cube that leaves 64 bits saturates and therefore never fits.
		assign cube_full = CUBE_W'(sq_a_s[k]) * CUBE_W'(c_a_s[k]);
		assign fits = (cube_full[CUBE_W-1:SAT_W] == '0)
			&& (NUM_W'(cube_full[SAT_W-1:Q_BITS]) <= x_a_s[k]);
		always_ff @(posedge clk) begin
			if (en) begin
				r_b_s[k] <= fits ? c_a_s[k] : r_a_s[k];
				x_b_s[k] <= x_a_s[k];
				side_b_s[k] <= side_a_s[k];
			end
		end
	end

	assign root = r_b_s[ROOT_W-1];
	assign side_out = side_b_s[ROOT_W-1];
endmodule

@@ hdl/srgblab_back.sv @@
// Back end: matrix, white division, cube root or linear segment, Lab forming and output register.
`include "srgb_to_cielab_unit_macros.svh"
module srgblab_back #(
	parameter int FRAC_BITS = srgblab_pkg::FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input srgblab_pkg::lin_rgb_t lin,
	input srgblab_pkg::fifo_stat_t stat,
	output logic pop,
	input logic [srgblab_pkg::WHITE_W-1:0] white_x,
	input logic [srgblab_pkg::WHITE_W-1:0] white_y,
	input logic [srgblab_pkg::WHITE_W-1:0] white_z,
	output logic lab_valid,
	input logic lab_ready,
	output srgblab_pkg::lab_t lab
);
	import srgblab_pkg::*;

	localparam int LAT = 3 + NUM_W + 2 * ROOT_W + 3;
	localparam int SHIFT = Q_BITS - FRAC_BITS;
	localparam int SIDE_W = VLIN_W + 1;
	localparam logic signed [RES_W-1:0] HALF = RES_W'(1) << (SHIFT - 1);

	logic adv;
	logic [LAT-1:0] vld_s;
	logic lab_valid_q;
	lab_t lab_q;

	logic [LIN_W-1:0] lin_in [3];
	logic [WHITE_W-1:0] white [3];
	logic [WHITE_W-1:0] den [3];
	logic [XYZ_W-1:0] prod_s1 [3][3];
	logic [XYZ_W-1:0] xyz_s2 [3];
	logic [NUM_W-1:0] num_s3 [3];
	logic [NUM_W-1:0] v_div [3];
	logic [SIDE_W-1:0] side_root [3];
	logic [ROOT_W-1:0] root [3];
	logic [ROOT_W-1:0] root_l1 [3];
	logic [LN_W-1:0] n_l1 [3];
	logic sel_l1 [3];
	logic [F_W-1:0] f_l2 [3];
	logic signed [RES_W-1:0] res_o1 [3];
	logic signed [RES_W-1:0] rnd [3];
	logic signed [F_W:0] fx;
	logic signed [F_W:0] fy;
	logic signed [F_W:0] fz;
	lab_t lab_next;

	// The whole pipeline moves only while the output register can take a result.
	assign adv = !lab_valid_q || lab_ready;
	assign pop = adv && stat.has_data;
	assign lab_valid = lab_valid_q;
	assign lab = lab_q;

	assign lin_in[0] = lin.r;
	assign lin_in[1] = lin.g;
	assign lin_in[2] = lin.b;
	assign white[0] = white_x;
	assign white[1] = white_y;
	assign white[2] = white_z;

	for (genvar i = 0; i < 3; i++) begin : g_comp
		logic [63:0] recip_full;
		assign den[i] = (white[i] == '0) ? WHITE_W'(1) : white[i];

		for (genvar j = 0; j < 3; j++) begin : g_term
			always_ff @(posedge clk) begin
				if (adv) prod_s1[i][j] <= XYZ_W'(lin_in[j]) * XYZ_W'(MATRIX[i][j]);
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				xyz_s2[i] <= prod_s1[i][0] + prod_s1[i][1] + prod_s1[i][2];
				num_s3[i] <= (NUM_W'(xyz_s2[i]) << 3) + (NUM_W'(xyz_s2[i]) << 1)
					+ NUM_W'(white[i] >> 1);
			end
		end

		srgblab_div u_div (
			.clk(clk),
			.en(adv),
			.num(num_s3[i]),
			.den(den[i]),
			.quo(v_div[i])
		);

		srgblab_cbrt #(.SIDE_W(SIDE_W)) u_cbrt (
			.clk(clk),
			.en(adv),
			.x(v_div[i]),
			.side_in({v_div[i] > KNEE_V, v_div[i][VLIN_W-1:0]}),
			.root(root[i]),
			.side_out(side_root[i])
		);

		// Linear segment: divide by 1000 through a reciprocal that is exact below 2^31.
		assign recip_full = 64'(n_l1[i]) * 64'(RECIP_1000);

		always_ff @(posedge clk) begin
			if (adv) begin
				root_l1[i] <= root[i];
				sel_l1[i] <= side_root[i][VLIN_W];
				n_l1[i] <= LN_W'(side_root[i][VLIN_W-1:0]) * LIN_SLOPE + LIN_ROUND;
				f_l2[i] <= sel_l1[i] ? F_W'(root_l1[i])
					: F_W'(recip_full >> RECIP_SHIFT) + F_OFFSET;
			end
		end

		assign rnd[i] = (res_o1[i] + HALF) >>> SHIFT;
	end

	assign fx = $signed({1'b0, f_l2[0]});
	assign fy = $signed({1'b0, f_l2[1]});
	assign fz = $signed({1'b0, f_l2[2]});

	always_ff @(posedge clk) begin
		if (adv) begin
			res_o1[0] <= RES_W'(fy) * RES_W'(116) - (RES_W'(16) << Q_BITS);
			res_o1[1] <= (RES_W'(fx) - RES_W'(fy)) * RES_W'(500);
			res_o1[2] <= (RES_W'(fy) - RES_W'(fz)) * RES_W'(200);
		end
	end

	always_comb begin
		if (rnd[0] < 0) lab_next.lightness = '0;
		else if (rnd[0] > RES_W'(L_MAX)) lab_next.lightness = 15'(L_MAX);
		else lab_next.lightness = rnd[0][14:0];
		if (rnd[1] < RES_W'(AB_MIN)) lab_next.a_star = 16'(AB_MIN);
		else if (rnd[1] > RES_W'(AB_MAX)) lab_next.a_star = 16'(AB_MAX);
		else lab_next.a_star = rnd[1][15:0];
		if (rnd[2] < RES_W'(AB_MIN)) lab_next.b_star = 16'(AB_MIN);
		else if (rnd[2] > RES_W'(AB_MAX)) lab_next.b_star = 16'(AB_MAX);
		else lab_next.b_star = rnd[2][15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
			lab_valid_q <= 1'b0;
		end else if (adv) begin
			vld_s <= {vld_s[LAT-2:0], stat.has_data};
			lab_valid_q <= vld_s[LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) lab_q <= lab_next;
	end

	`SRGBLAB_ASSERT(a_hold_on_stall, clk, arst_n, !adv |=> $stable(vld_s))
	`SRGBLAB_ASSERT(a_result_from_pipe, clk, arst_n, $rose(lab_valid_q) |-> $past(vld_s[LAT-1]))
endmodule

@@ hdl/srgb_to_cielab_unit.sv @@
// Each pixel passes the front-end lookup register, the queue, then the back pipeline.
// Throughput: one pixel per clock; the 108-stage back pipeline (42-stage divider, 60-stage
// cube root) advances as a whole whenever the output register is free or being read.
// A four-entry queue lets the front end keep taking pixels while the back end is stalled.
// Reset clears all valid state and loads the D65 reference white; there is no clearing pass.
module srgb_to_cielab_unit #(
	parameter int FRAC_BITS = srgblab_pkg::FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic pixel_valid,
	output logic pixel_ready,
	input srgblab_pkg::pixel_t pixel,
	output logic lab_valid,
	input logic lab_ready,
	output srgblab_pkg::lab_t lab,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [srgblab_pkg::WHITE_W-1:0] cfg_data
);
	import srgblab_pkg::*;

	logic [WHITE_W-1:0] white_x_q;
	logic [WHITE_W-1:0] white_y_q;
	logic [WHITE_W-1:0] white_z_q;
	fifo_stat_t stat;
	logic push;
	logic pop;
	lin_rgb_t lin_front;
	lin_rgb_t lin_back;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			white_x_q <= WHITE_X_RST;
			white_y_q <= WHITE_Y_RST;
			white_z_q <= WHITE_Z_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_WHITE_X: white_x_q <= cfg_data;
				REG_WHITE_Y: white_y_q <= cfg_data;
				REG_WHITE_Z: white_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	srgblab_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.pixel_valid(pixel_valid),
		.pixel_ready(pixel_ready),
		.pixel(pixel),
		.stat(stat),
		.push(push),
		.lin(lin_front)
	);

	srgblab_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wdata(lin_front),
		.pop(pop),
		.rdata(lin_back),
		.stat(stat)
	);

	srgblab_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.lin(lin_back),
		.stat(stat),
		.pop(pop),
		.white_x(white_x_q),
		.white_y(white_y_q),
		.white_z(white_z_q),
		.lab_valid(lab_valid),
		.lab_ready(lab_ready),
		.lab(lab)
	);
endmodule

@@ test/tb_srgb_to_cielab_unit.sv @@
// Self-checking testbench for the sRGB to CIELAB conversion unit.
module tb_srgb_to_cielab_unit;
	import srgblab_pkg::*;

	localparam int SHIFT_OUT = Q_BITS - FRAC_BITS_DEF;
	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int DRAIN_CYCLES = 120;

	logic clk;
	logic arst_n;
	logic pixel_valid;
	logic pixel_ready;
	pixel_t pixel;
	logic lab_valid;
	logic lab_ready;
	lab_t lab;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [WHITE_W-1:0] cfg_data;

	logic [63:0] lin_lut [256];
	logic [WHITE_W-1:0] ref_white [3];
	lab_t lab_expected [$];
	int fail_count;
	bit tx_idle_on;
	bit rx_idle_on;
	int rx_hold;
	int rx_stall;

	srgb_to_cielab_unit dut (
		.clk(clk), .arst_n(arst_n),
		.pixel_valid(pixel_valid), .pixel_ready(pixel_ready), .pixel(pixel),
		.lab_valid(lab_valid), .lab_ready(lab_ready), .lab(lab),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3000000;
		$display("Some tests failed");
		$finish;
	end

	// Truncated Q24 power that saturates once the product leaves 64 bits.
	function automatic logic [63:0] q24_power(input logic [63:0] r, input int n);
		logic [127:0] prod;
		logic [63:0] p;
		p = r;
		for (int i = 1; i < n; i++) begin
			prod = 128'(p) * 128'(r);
			if (prod[127:64] != 64'd0) return '1;
			p = prod[87:24];
		end
		return p;
	endfunction

	function automatic logic [63:0] q24_root(input logic [63:0] x, input int n);
		logic [63:0] r;
		logic [63:0] c;
		r = '0;
		for (int b = 29; b >= 0; b--) begin
			c = r | (64'd1 << b);
			if (q24_power(c, n) <= x) r = c;
		end
		return r;
	endfunction

	function automatic logic [63:0] linear_light(input int code);
		logic [63:0] c;
		logic [63:0] t;
		logic [63:0] u;
		c = 64'(code);
		if (c <= 64'd10) return (c * 64'd100 * (64'd1 << 24) + 64'd164730) / 64'd329460;
		t = ((c * 64'd1000 + 64'd14025) * (64'd1 << 24) + 64'd134512) / 64'd269025;
		u = (t * t) >> 24;
		return (u * q24_root(u, 5)) >> 24;
	endfunction

	// Cube root above the knee, the linear segment below it.
	function automatic logic signed [63:0] lab_curve(input logic [63:0] comp,
			input logic [WHITE_W-1:0] white);
		logic [63:0] w;
		logic [63:0] v;
		w = (white == '0) ? 64'd1 : 64'(white);
		v = (comp * 64'd10 + w / 64'd2) / w;
		if (v * 64'd1000000 > 64'd8856 * (64'd1 << 24)) return q24_root(v, 3);
		return (v * 64'd7787 + 64'd500) / 64'd1000 + ((64'd16 << 24) + 64'd58) / 64'd116;
	endfunction

	function automatic logic signed [63:0] round_out(input logic signed [63:0] v);
		return (v + (64'sd1 <<< (SHIFT_OUT - 1))) >>> SHIFT_OUT;
	endfunction

	function automatic lab_t convert_pixel(input pixel_t p);
		logic [63:0] r, g, b, x, y, z;
		logic signed [63:0] fx, fy, fz, l, a, bb;
		lab_t res;
		r = lin_lut[p.red];
		g = lin_lut[p.green];
		b = lin_lut[p.blue];
		x = 4124 * r + 3576 * g + 1805 * b;
		y = 2126 * r + 7152 * g + 722 * b;
		z = 193 * r + 1192 * g + 9505 * b;
		fx = lab_curve(x, ref_white[REG_WHITE_X]);
		fy = lab_curve(y, ref_white[REG_WHITE_Y]);
		fz = lab_curve(z, ref_white[REG_WHITE_Z]);
		l = round_out(116 * fy - (64'sd16 <<< 24));
		a = round_out(500 * (fx - fy));
		bb = round_out(200 * (fy - fz));
		if (l < 0) l = 0;
		if (l > L_MAX) l = L_MAX;
		if (a < AB_MIN) a = AB_MIN;
		if (a > AB_MAX) a = AB_MAX;
		if (bb < AB_MIN) bb = AB_MIN;
		if (bb > AB_MAX) bb = AB_MAX;
		res.lightness = l[14:0];
		res.a_star = a[15:0];
		res.b_star = bb[15:0];
		return res;
	endfunction

	// The gap is drawn first so that valid is lowered in the step of the last transfer.
	task automatic send_pixel(input pixel_t p);
		int gap;
		gap = tx_idle_on ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			pixel_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pixel_valid <= 1'b1;
		pixel <= p;
		do @(posedge clk); while (!pixel_ready);
		lab_expected.push_back(convert_pixel(p));
	endtask

	task automatic wait_drained();
		if (pixel_valid) begin
			pixel_valid <= 1'b0;
		end
		while (lab_expected.size() != 0) @(posedge clk);
	endtask

	task automatic write_white(input logic [1:0] idx, input logic [WHITE_W-1:0] val);
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx != REG_UNUSED) ref_white[idx] = val;
	endtask

	function automatic pixel_t random_pixel();
		pixel_t p;
		p = pixel_t'($urandom);
		return p;
	endfunction

	// Receiver: checks every transfer and draws a stall after each one.
	always @(posedge clk) begin
		lab_t want;
		logic next_ready;
		if (arst_n && lab_valid && lab_ready) begin
			if (lab_expected.size() == 0) begin
				$display("%0t: unexpected result %h", $realtime, lab);
				fail_count++;
			end else begin
				want = lab_expected.pop_front();
				if (lab.lightness !== want.lightness) begin
					$display("%0t: lightness expected %0d actual %0d", $realtime,
						want.lightness, lab.lightness);
					fail_count++;
				end
				if (lab.a_star !== want.a_star) begin
					$display("%0t: a_star expected %0d actual %0d", $realtime,
						want.a_star, lab.a_star);
					fail_count++;
				end
				if (lab.b_star !== want.b_star) begin
					$display("%0t: b_star expected %0d actual %0d", $realtime,
						want.b_star, lab.b_star);
					fail_count++;
				end
			end
			rx_stall = rx_idle_on ? $urandom_range(0, 3) : 0;
		end
		next_ready = 1'b1;
		if (rx_hold > 0) begin
			rx_hold--;
			next_ready = 1'b0;
		end else if (rx_stall > 0) begin
			rx_stall--;
			next_ready = 1'b0;
		end
		lab_ready <= next_ready;
	end

	task automatic test_corners();
		pixel_t p;
		int codes [12] = '{0, 1, 9, 10, 11, 12, 127, 128, 200, 254, 255, 85};
		foreach (codes[i]) begin
			p.red = 8'(codes[i]);
			p.green = 8'(codes[i]);
			p.blue = 8'(codes[i]);
			send_pixel(p);
		end
		send_pixel({8'd255, 8'd0, 8'd0});
		send_pixel({8'd0, 8'd255, 8'd0});
		send_pixel({8'd0, 8'd0, 8'd255});
		send_pixel({8'd255, 8'd255, 8'd0});
		send_pixel({8'd0, 8'd255, 8'd255});
		send_pixel({8'd255, 8'd0, 8'd255});
		send_pixel({8'd10, 8'd11, 8'd10});
		send_pixel({8'hAA, 8'h55, 8'hAA});
		send_pixel({8'h55, 8'hAA, 8'h55});
		wait_drained();
	endtask

	// Extreme, zero and out-of-range white values; a write to the unused index is ignored.
	task automatic test_white_settings();
		logic [WHITE_W-1:0] whites [5] = '{18'd1, 18'd200000, 18'd0, 18'h3FFFF, 18'd50000};
		foreach (whites[i]) begin
			write_white(REG_WHITE_X, whites[i]);
			write_white(REG_WHITE_Y, whites[(i + 1) % 5]);
			write_white(REG_WHITE_Z, whites[(i + 2) % 5]);
			write_white(REG_UNUSED, 18'($urandom));
			repeat (12) send_pixel(random_pixel());
			send_pixel({8'd0, 8'd0, 8'd0});
			send_pixel({8'd255, 8'd255, 8'd255});
		end
		write_white(REG_WHITE_X, WHITE_X_RST);
		write_white(REG_WHITE_Y, WHITE_Y_RST);
		write_white(REG_WHITE_Z, WHITE_Z_RST);
	endtask

	// Enough pixels to fill the frozen pipeline and the queue so the input stalls.
	task automatic test_backpressure();
		rx_hold = 400;
		repeat (200) send_pixel(random_pixel());
		wait_drained();
	endtask

	task automatic test_random_stream();
		for (int phase = 0; phase < 6; phase++) begin
			if (phase == 3) begin
				write_white(REG_WHITE_X, 18'($urandom_range(80000, 120000)));
				write_white(REG_WHITE_Y, 18'($urandom_range(80000, 120000)));
				write_white(REG_WHITE_Z, 18'($urandom_range(80000, 120000)));
			end
			tx_idle_on = (phase != 1);
			rx_idle_on = (phase != 2);
			for (int i = 0; i < 280; i++) begin
				send_pixel(random_pixel());
			end
			// Pause the sender until everything in flight has come out.
			wait_drained();
		end
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	initial begin
		arst_n = 1'b0;
		pixel_valid = 1'b0;
		pixel = '0;
		lab_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_WHITE_X;
		cfg_data = '0;
		fail_count = 0;
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		rx_hold = 0;
		rx_stall = 0;
		ref_white[REG_WHITE_X] = WHITE_X_RST;
		ref_white[REG_WHITE_Y] = WHITE_Y_RST;
		ref_white[REG_WHITE_Z] = WHITE_Z_RST;
		for (int i = 0; i < 256; i++) lin_lut[i] = linear_light(i);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corners();
		test_white_settings();
		test_backpressure();
		test_random_stream();

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && lab_expected.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule

@@ srgb_to_cielab_unit.f @@
+incdir+hdl
hdl/srgblab_pkg.sv
hdl/srgblab_front.sv
hdl/srgblab_fifo.sv
hdl/srgblab_div.sv
hdl/srgblab_cbrt.sv
hdl/srgblab_back.sv
hdl/srgb_to_cielab_unit.sv
test/tb_srgb_to_cielab_unit.sv
